>>> rtl/assert_macros.svh
// Assertion macros used by the checker file of this block.
// Each macro takes a label, a clock, an active-low reset, a condition and a consequence.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequence must hold in the same cycle as the condition.
`define ASSERT_SAME(label, clk, rst_n, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
		else $error("assertion failed: same-cycle property violated");

// The consequence must hold in the cycle after the condition.
`define ASSERT_NEXT(label, clk, rst_n, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
		else $error("assertion failed: next-cycle property violated");

`endif

>>> rtl/spcd_pkg.sv
// Package for the smart plug command decoder: command codes, limits and sizes.
// No dependencies; used by the core and by its checker.
`timescale 1ns / 1ps

package spcd_pkg;

	// Number of timer groups; the timer table holds an on-time and an off-time per group.
	localparam int GROUP_COUNT   = 3;
	localparam int TIMER_ENTRIES = 2 * GROUP_COUNT;
	localparam int TIMER_IDX_W   = (TIMER_ENTRIES > 1) ? $clog2(TIMER_ENTRIES) : 1;
	// Wide enough for an index plus one and never narrower than the slot output.
	localparam int SLOT_CALC_W   = TIMER_IDX_W + 3;

	localparam logic [7:0] INIT_HEADER     = 8'hF0;
	localparam logic [3:0] STATUS_CODE_LOW = 4'h2;
	localparam logic [6:0] DUTY_MAX        = 7'd100;
	localparam logic [7:0] DIMMER_GROUP    = 8'd1;

	typedef enum logic [3:0] {
		CMD_ACK       = 4'h1,
		CMD_STATUS    = 4'h3,
		CMD_SWITCH    = 4'h9,
		CMD_ON_TIMER  = 4'hA,
		CMD_OFF_TIMER = 4'hB,
		CMD_SET_TIME  = 4'hC,
		CMD_DIMMER    = 4'hD
	} cmd_t;

	typedef struct packed {
		logic       power;
		logic       status;
		logic       normal;
	} reply_flags_t;

endpackage

>>> rtl/smart_plug_command_decoder_core.sv
// Smart plug command decoder: one received frame in, one status result out.
// Usage:
//   Frames enter on the in channel (in_valid, in_stall); a frame transfers
//   when in_valid is high and in_stall is low. Results leave on the out
//   channel (out_valid, out_stall) under the same rule.
//   The device id mask is written through cfg_wr_en / cfg_wr_data while idle.
// Pipeline and throughput:
//   A frame is captured in an input register, decoded combinationally from it
//   and its result lands in the output register. One frame per cycle is
//   sustained while out_stall is low; the single decode stage that reads and
//   updates the plug state is the only step per frame.
// Stalls:
//   While out_stall holds a result, the input register keeps its frame and
//   in_stall rises only once that register is full.
// Reset:
//   arst_n clears the link, reply, switch, dimmer, timer and clock state and
//   the mask; both channels come up empty.
// Depends on spcd_pkg.
`timescale 1ns / 1ps

module smart_plug_command_decoder_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] header,
	input  logic [15:0] type_word,
	input  logic [7:0] group_byte,
	input  logic [7:0] first_arg,
	input  logic [7:0] second_arg,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       accepted,
	output logic       switch_on,
	output logic       switch_changed,
	output logic [6:0] duty_percent,
	output logic [2:0] reply_pending,
	output logic [7:0] status_reply_code,
	output logic [7:0] normal_reply_code,
	output logic       app_controlled,
	output logic       clock_load,
	output logic       repeat_clear,
	output logic [2:0] timer_slot_written
);
	import spcd_pkg::*;

	// Input register stage.
	logic       valid_s1;
	logic [7:0] header_s1;
	logic [15:0] type_s1;
	logic [7:0] group_s1;
	logic [7:0] arg1_s1;
	logic [7:0] arg2_s1;

	// Plug state.
	logic [15:0] mask_q;
	logic        link_ready_q;
	reply_flags_t reply_q;
	logic [7:0]  status_code_q;
	logic [7:0]  normal_code_q;
	logic        app_flag_q;
	logic        switch_q;
	logic [6:0]  duty_q;
	logic [15:0] timer_table_q [TIMER_ENTRIES];
	logic [23:0] clock_time_q;

	// Next-state and strobe logic.
	logic        advance;
	logic        take;
	logic        link_ready_d;
	reply_flags_t reply_d;
	logic [7:0]  status_code_d;
	logic [7:0]  normal_code_d;
	logic        app_flag_d;
	logic        switch_d;
	logic [6:0]  duty_d;
	logic        accepted_d;
	logic        changed_d;
	logic        cload_d;
	logic        rclear_d;
	logic [2:0]  slot_d;
	logic        timer_we;
	logic [TIMER_IDX_W-1:0] timer_idx;
	logic [SLOT_CALC_W-1:0] slot_wide;
	logic [7:0]  group_m1;
	logic        group_ok;
	logic [6:0]  duty_sat;
	logic        switch_req;

	// The output register can take a new result when it is empty or draining.
	assign advance  = !out_valid || !out_stall;
	assign take     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	assign group_m1  = group_s1 - 8'd1;
	assign group_ok  = (group_s1 >= 8'd1) && (group_s1 <= 8'(GROUP_COUNT));
	assign duty_sat  = (arg1_s1 > {1'b0, DUTY_MAX}) ? DUTY_MAX : arg1_s1[6:0];
	assign switch_req = (arg1_s1 != 8'd0);
	assign slot_wide = SLOT_CALC_W'(timer_idx) + SLOT_CALC_W'(1);

	always_comb begin
		link_ready_d  = link_ready_q;
		reply_d       = reply_q;
		status_code_d = status_code_q;
		normal_code_d = normal_code_q;
		app_flag_d    = app_flag_q;
		switch_d      = switch_q;
		duty_d        = duty_q;
		accepted_d    = 1'b0;
		cload_d       = 1'b0;
		rclear_d      = 1'b0;
		timer_we      = 1'b0;
		timer_idx     = group_m1[TIMER_IDX_W-1:0];
		if (!link_ready_q) begin
			if (header_s1 == INIT_HEADER) begin
				link_ready_d  = 1'b1;
				reply_d.power = 1'b1;
				rclear_d      = 1'b1;
				accepted_d    = 1'b1;
			end
		end else if ((type_s1 & mask_q) == mask_q) begin
			accepted_d = 1'b1;
			unique case (cmd_t'(header_s1[3:0]))
				CMD_ACK: begin
					rclear_d = 1'b1;
					// Pending replies are retired one at a time, power first.
					priority if (reply_q.power) begin
						reply_d.power  = 1'b0;
						reply_d.status = 1'b1;
						status_code_d  = {4'h0, STATUS_CODE_LOW};
					end else if (reply_q.status) begin
						reply_d.status = 1'b0;
					end else if (reply_q.normal) begin
						reply_d.normal = 1'b0;
					end else begin
					end
				end
				CMD_STATUS: begin
					rclear_d       = 1'b1;
					reply_d.status = 1'b1;
					status_code_d  = {header_s1[7:4], STATUS_CODE_LOW};
				end
				CMD_SWITCH: begin
					rclear_d       = 1'b1;
					reply_d.normal = 1'b1;
					normal_code_d  = header_s1;
					app_flag_d     = 1'b1;
					switch_d       = switch_req;
				end
				CMD_ON_TIMER, CMD_OFF_TIMER: begin
					rclear_d       = 1'b1;
					reply_d.normal = 1'b1;
					normal_code_d  = header_s1;
					timer_we       = group_ok;
					if (header_s1[3:0] == CMD_OFF_TIMER) begin
						timer_idx = group_m1[TIMER_IDX_W-1:0] + TIMER_IDX_W'(GROUP_COUNT);
					end
				end
				CMD_SET_TIME: begin
					rclear_d       = 1'b1;
					reply_d.normal = 1'b1;
					normal_code_d  = header_s1;
					cload_d        = 1'b1;
				end
				CMD_DIMMER: begin
					rclear_d       = 1'b1;
					reply_d.normal = 1'b1;
					normal_code_d  = header_s1;
					// A zero duty turns the plug off, any other duty turns it on.
					if (group_s1 == DIMMER_GROUP) begin
						duty_d   = duty_sat;
						switch_d = (duty_sat != 7'd0);
					end
				end
				default: begin
				end
			endcase
		end
		changed_d = (switch_d != switch_q);
		slot_d    = timer_we ? slot_wide[2:0] : 3'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			header_s1 <= header;
			type_s1   <= type_word;
			group_s1  <= group_byte;
			arg1_s1   <= first_arg;
			arg2_s1   <= second_arg;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (cfg_wr_en) begin
			mask_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_ready_q  <= 1'b0;
			reply_q       <= '0;
			status_code_q <= '0;
			normal_code_q <= '0;
			app_flag_q    <= 1'b0;
			switch_q      <= 1'b0;
			duty_q        <= '0;
			clock_time_q  <= '0;
			for (int i = 0; i < TIMER_ENTRIES; i++) begin
				timer_table_q[i] <= '0;
			end
		end else if (take) begin
			link_ready_q  <= link_ready_d;
			reply_q       <= reply_d;
			status_code_q <= status_code_d;
			normal_code_q <= normal_code_d;
			app_flag_q    <= app_flag_d;
			switch_q      <= switch_d;
			duty_q        <= duty_d;
			if (cload_d) begin
				clock_time_q <= {group_s1, arg1_s1, arg2_s1};
			end
			if (timer_we) begin
				timer_table_q[timer_idx] <= {arg1_s1, arg2_s1};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			accepted           <= accepted_d;
			switch_on          <= switch_d;
			switch_changed     <= changed_d;
			duty_percent       <= duty_d;
			reply_pending      <= {reply_d.normal, reply_d.status, reply_d.power};
			status_reply_code  <= status_code_d;
			normal_reply_code  <= normal_code_d;
			app_controlled     <= app_flag_d;
			clock_load         <= cload_d;
			repeat_clear       <= rclear_d;
			timer_slot_written <= slot_d;
		end
	end

endmodule

>>> rtl/spcd_checker.sv
// Port-level checker for the smart plug command decoder, bound to the core.
// Depends on spcd_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module spcd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic       accepted,
	input logic       switch_on,
	input logic       switch_changed,
	input logic [6:0] duty_percent,
	input logic [2:0] reply_pending,
	input logic       clock_load,
	input logic       repeat_clear,
	input logic [2:0] timer_slot_written
);
	import spcd_pkg::*;

	// A held result keeps its contents until the transfer.
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(switch_on) && $stable(duty_percent) && $stable(reply_pending))

	// A draining output always frees the input side.
	`ASSERT_SAME(a_no_stall_when_draining, clk, arst_n, out_valid && !out_stall, !in_stall)

	// Any action strobe belongs to an accepted frame that also clears the repeat logic.
	`ASSERT_SAME(a_strobes_need_accept, clk, arst_n, out_valid && (switch_changed || clock_load || (timer_slot_written != 3'd0)), accepted && repeat_clear)

	// The dimmer duty never exceeds its saturation value.
	`ASSERT_SAME(a_duty_range, clk, arst_n, out_valid, duty_percent <= DUTY_MAX)

	// A rejected frame leaves no strobes behind.
	`ASSERT_SAME(a_reject_quiet, clk, arst_n, out_valid && !accepted, !repeat_clear && !switch_changed && !clock_load)

endmodule

bind smart_plug_command_decoder_core spcd_checker u_spcd_checker (.*);

>>> tb/tb_smart_plug_command_decoder_core.sv
// Testbench for smart_plug_command_decoder_core: directed and random command frames checked
// against a cycle-free model of the plug state, with random stalls on both channels.
// Depends on spcd_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_smart_plug_command_decoder_core;
	import spcd_pkg::*;

	localparam int HOLD_CYCLES = 60;
	localparam int IDLE_PCT    = 24;

	typedef struct packed {
		logic [7:0]  header;
		logic [15:0] type_word;
		logic [7:0]  group;
		logic [7:0]  arg1;
		logic [7:0]  arg2;
	} plug_frame_t;

	typedef struct packed {
		logic       accepted;
		logic       switch_on;
		logic       switch_changed;
		logic [6:0] duty;
		logic [2:0] reply;
		logic [7:0] status_code;
		logic [7:0] normal_code;
		logic       app;
		logic       clock_load;
		logic       repeat_clear;
		logic [2:0] slot;
	} plug_status_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [15:0] cfg_wr_data;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  header;
	logic [15:0] type_word;
	logic [7:0]  group_byte;
	logic [7:0]  first_arg;
	logic [7:0]  second_arg;
	logic        out_valid;
	logic        out_stall;
	logic        accepted;
	logic        switch_on;
	logic        switch_changed;
	logic [6:0]  duty_percent;
	logic [2:0]  reply_pending;
	logic [7:0]  status_reply_code;
	logic [7:0]  normal_reply_code;
	logic        app_controlled;
	logic        clock_load;
	logic        repeat_clear;
	logic [2:0]  timer_slot_written;

	smart_plug_command_decoder_core i_dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_wr_en          (cfg_wr_en),
		.cfg_wr_data        (cfg_wr_data),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.header             (header),
		.type_word          (type_word),
		.group_byte         (group_byte),
		.first_arg          (first_arg),
		.second_arg         (second_arg),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.accepted           (accepted),
		.switch_on          (switch_on),
		.switch_changed     (switch_changed),
		.duty_percent       (duty_percent),
		.reply_pending      (reply_pending),
		.status_reply_code  (status_reply_code),
		.normal_reply_code  (normal_reply_code),
		.app_controlled     (app_controlled),
		.clock_load         (clock_load),
		.repeat_clear       (repeat_clear),
		.timer_slot_written (timer_slot_written)
	);

	always #2 clk = ~clk;

	// Model copy of the plug state.
	logic        mdl_link_ready;
	logic        mdl_power_flag;
	logic        mdl_status_flag;
	logic        mdl_normal_flag;
	logic [7:0]  mdl_status_code;
	logic [7:0]  mdl_normal_code;
	logic        mdl_app;
	logic        mdl_switch;
	logic [6:0]  mdl_duty;
	logic [15:0] mdl_timer [TIMER_ENTRIES];
	logic [23:0] mdl_clock;
	logic [15:0] mdl_mask;

	plug_status_t status_q [$];
	int           fail_count;
	int           mismatch_count;
	logic         sender_quiet;
	logic         receiver_quiet;
	int           holds_asked;
	int           holds_served;
	int           hold_left;

	function automatic plug_status_t decode_frame(input plug_frame_t f);
		plug_status_t r;
		int unsigned  idx;
		r = '0;
		if (!mdl_link_ready) begin
			if (f.header == INIT_HEADER) begin
				mdl_link_ready = 1'b1;
				mdl_power_flag = 1'b1;
				r.repeat_clear = 1'b1;
				r.accepted     = 1'b1;
			end
		end else if ((f.type_word & mdl_mask) == mdl_mask) begin
			r.accepted = 1'b1;
			case (f.header[3:0])
				CMD_ACK: begin
					r.repeat_clear = 1'b1;
					// Replies are retired one at a time: power first, then status, then normal.
					if (mdl_power_flag) begin
						mdl_power_flag  = 1'b0;
						mdl_status_flag = 1'b1;
						mdl_status_code = {4'h0, STATUS_CODE_LOW};
					end else if (mdl_status_flag) begin
						mdl_status_flag = 1'b0;
					end else if (mdl_normal_flag) begin
						mdl_normal_flag = 1'b0;
					end
				end
				CMD_STATUS: begin
					r.repeat_clear  = 1'b1;
					mdl_status_flag = 1'b1;
					mdl_status_code = {f.header[7:4], STATUS_CODE_LOW};
				end
				CMD_SWITCH: begin
					r.repeat_clear  = 1'b1;
					mdl_normal_flag = 1'b1;
					mdl_normal_code = f.header;
					mdl_app         = 1'b1;
					if (mdl_switch != (f.arg1 != 8'd0)) begin
						mdl_switch       = (f.arg1 != 8'd0);
						r.switch_changed = 1'b1;
					end
				end
				CMD_ON_TIMER, CMD_OFF_TIMER: begin
					r.repeat_clear  = 1'b1;
					mdl_normal_flag = 1'b1;
					mdl_normal_code = f.header;
					if (f.group >= 8'd1 && f.group <= GROUP_COUNT) begin
						idx = f.group - 1;
						if (f.header[3:0] == CMD_OFF_TIMER)
							idx += GROUP_COUNT;
						mdl_timer[idx] = {f.arg1, f.arg2};
						r.slot = 3'(idx + 1);
					end
				end
				CMD_SET_TIME: begin
					r.repeat_clear  = 1'b1;
					mdl_normal_flag = 1'b1;
					mdl_normal_code = f.header;
					mdl_clock       = {f.group, f.arg1, f.arg2};
					r.clock_load    = 1'b1;
				end
				CMD_DIMMER: begin
					r.repeat_clear  = 1'b1;
					mdl_normal_flag = 1'b1;
					mdl_normal_code = f.header;
					if (f.group == DIMMER_GROUP) begin
						mdl_duty = (f.arg1 > DUTY_MAX) ? DUTY_MAX : f.arg1[6:0];
						if (mdl_duty == 7'd0 && mdl_switch) begin
							mdl_switch       = 1'b0;
							r.switch_changed = 1'b1;
						end
						if (!mdl_switch && mdl_duty != 7'd0) begin
							mdl_switch       = 1'b1;
							r.switch_changed = 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
		r.switch_on   = mdl_switch;
		r.duty        = mdl_duty;
		r.reply       = {mdl_normal_flag, mdl_status_flag, mdl_power_flag};
		r.status_code = mdl_status_code;
		r.normal_code = mdl_normal_code;
		r.app         = mdl_app;
		return r;
	endfunction

	function automatic plug_frame_t make_frame(input logic [7:0] h, input logic [15:0] t,
		input logic [7:0] g, input logic [7:0] a1, input logic [7:0] a2);
		plug_frame_t f;
		f = '{header: h, type_word: t, group: g, arg1: a1, arg2: a2};
		return f;
	endfunction

	// Mostly well-formed frames that pass the id check, with some noise mixed in.
	function automatic plug_frame_t random_frame();
		plug_frame_t f;
		logic [3:0]  nib;
		case ($urandom_range(0, 6))
			0: nib = CMD_ACK;
			1: nib = CMD_STATUS;
			2: nib = CMD_SWITCH;
			3: nib = CMD_ON_TIMER;
			4: nib = CMD_OFF_TIMER;
			5: nib = CMD_SET_TIME;
			default: nib = CMD_DIMMER;
		endcase
		if ($urandom_range(0, 99) < 85)
			f.header = {4'($urandom), nib};
		else
			f.header = 8'($urandom);
		if ($urandom_range(0, 99) < 75)
			f.type_word = mdl_mask | 16'($urandom);
		else
			f.type_word = 16'($urandom);
		if ($urandom_range(0, 99) < 60)
			f.group = 8'($urandom_range(0, GROUP_COUNT + 1));
		else
			f.group = 8'($urandom);
		case ($urandom_range(0, 3))
			0: f.arg1 = 8'd0;
			1: f.arg1 = 8'($urandom_range(1, 100));
			2: f.arg1 = 8'($urandom_range(101, 255));
			default: f.arg1 = 8'($urandom);
		endcase
		f.arg2 = 8'($urandom);
		return f;
	endfunction

	task automatic send_frame(input plug_frame_t f);
		@(negedge clk);
		while (!sender_quiet && $urandom_range(0, 99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid   <= 1'b1;
		header     <= f.header;
		type_word  <= f.type_word;
		group_byte <= f.group;
		first_arg  <= f.arg1;
		second_arg <= f.arg2;
		do
			@(posedge clk);
		while (in_stall);
		status_q.push_back(decode_frame(f));
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (status_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_mask(input logic [15:0] value);
		wait_drained();
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		mdl_mask = value;
	endtask

	task automatic test_link_up();
		write_mask(16'h0000);
		// Frames before the init frame must be ignored.
		send_frame(make_frame(8'h09, 16'h0000, 8'h00, 8'h01, 8'h00));
		send_frame(make_frame(8'hFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF));
		send_frame(make_frame(INIT_HEADER, 16'h0000, 8'h00, 8'h00, 8'h00));
		// A second init frame falls on an unused command nibble.
		send_frame(make_frame(INIT_HEADER, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF));
		send_frame(make_frame(8'h01, 16'h1234, 8'h00, 8'h00, 8'h00));
		send_frame(make_frame(8'hF3, 16'h0000, 8'h00, 8'h00, 8'h00));
		send_frame(make_frame(8'h01, 16'h0000, 8'h00, 8'h00, 8'h00));
		send_frame(make_frame(8'h01, 16'h0000, 8'h00, 8'h00, 8'h00));
		send_frame(make_frame(8'h09, 16'h0000, 8'h00, 8'hFF, 8'h00));
		send_frame(make_frame(8'h01, 16'h0000, 8'h00, 8'h00, 8'h00));
		send_frame(make_frame(8'h79, 16'h0000, 8'h00, 8'h00, 8'h00));
	endtask

	task automatic test_commands();
		send_frame(make_frame(8'h0A, 16'h0000, 8'd0, 8'hFF, 8'hFF));
		send_frame(make_frame(8'h1A, 16'h0000, 8'd1, 8'hFF, 8'h00));
		send_frame(make_frame(8'h2A, 16'h0000, 8'd3, 8'h00, 8'hFF));
		send_frame(make_frame(8'h0B, 16'h0000, 8'd3, 8'h17, 8'h3B));
		send_frame(make_frame(8'h0B, 16'h0000, 8'd4, 8'h01, 8'h02));
		send_frame(make_frame(8'h0B, 16'h0000, 8'hFF, 8'h01, 8'h02));
		send_frame(make_frame(8'hFC, 16'h0000, 8'hFF, 8'hFF, 8'hFF));
		send_frame(make_frame(8'h0D, 16'h0000, 8'd1, 8'd50, 8'h00));
		send_frame(make_frame(8'h0D, 16'h0000, 8'd1, 8'hFF, 8'h00));
		send_frame(make_frame(8'h0D, 16'h0000, 8'd1, 8'd0, 8'h00));
		send_frame(make_frame(8'h0D, 16'h0000, 8'd1, 8'd101, 8'h00));
		send_frame(make_frame(8'h0D, 16'h0000, 8'd2, 8'd30, 8'h00));
		send_frame(make_frame(8'h02, 16'h0000, 8'h00, 8'h00, 8'h00));
		send_frame(make_frame(8'h0E, 16'h0000, 8'h00, 8'h00, 8'h00));
	endtask

	task automatic test_type_mask();
		write_mask(16'hFFFF);
		send_frame(make_frame(8'h09, 16'hFFFF, 8'h00, 8'h00, 8'h00));
		send_frame(make_frame(8'h09, 16'h7FFF, 8'h00, 8'h01, 8'h00));
	endtask

	task automatic test_random_traffic(input logic [15:0] mask, input int count);
		write_mask(mask);
		repeat (count)
			send_frame(random_frame());
	endtask

	// The receiver holds off while frames keep coming, so the input side must stall.
	task automatic test_backpressure();
		sender_quiet = 1'b1;
		holds_asked++;
		repeat (40)
			send_frame(random_frame());
		sender_quiet = 1'b0;
	endtask

	task automatic test_quiet_stream();
		sender_quiet   = 1'b1;
		receiver_quiet = 1'b1;
		repeat (250)
			send_frame(random_frame());
		wait_drained();
		sender_quiet   = 1'b0;
		receiver_quiet = 1'b0;
	endtask

	always @(negedge clk) begin
		if (holds_asked != holds_served) begin
			holds_served = holds_asked;
			hold_left    = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (receiver_quiet) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
		end
	end

	task automatic check_field(input string name, input logic [15:0] exp_v,
		input logic [15:0] act_v);
		if (exp_v !== act_v) begin
			mismatch_count++;
			fail_count++;
			if (mismatch_count <= 10)
				$display("mismatch %s: expected %0h, got %0h at %0t", name, exp_v, act_v, $realtime);
		end
	endtask

	always @(posedge clk) begin
		plug_status_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (status_q.size() == 0) begin
				mismatch_count++;
				fail_count++;
				if (mismatch_count <= 10)
					$display("unexpected result at %0t", $realtime);
			end else begin
				e = status_q.pop_front();
				check_field("accepted", e.accepted, accepted);
				check_field("switch_on", e.switch_on, switch_on);
				check_field("switch_changed", e.switch_changed, switch_changed);
				check_field("duty_percent", e.duty, duty_percent);
				check_field("reply_pending", e.reply, reply_pending);
				check_field("status_reply_code", e.status_code, status_reply_code);
				check_field("normal_reply_code", e.normal_code, normal_reply_code);
				check_field("app_controlled", e.app, app_controlled);
				check_field("clock_load", e.clock_load, clock_load);
				check_field("repeat_clear", e.repeat_clear, repeat_clear);
				check_field("timer_slot_written", e.slot, timer_slot_written);
			end
		end
	end

	initial begin
		#2_000_000;
		$display("FAIL");
		$finish;
	end

	initial begin
		arst_n          = 1'b0;
		cfg_wr_en       = 1'b0;
		cfg_wr_data     = '0;
		in_valid        = 1'b0;
		header          = '0;
		type_word       = '0;
		group_byte      = '0;
		first_arg       = '0;
		second_arg      = '0;
		out_stall       = 1'b0;
		fail_count      = 0;
		mismatch_count  = 0;
		sender_quiet    = 1'b0;
		receiver_quiet  = 1'b0;
		holds_asked     = 0;
		holds_served    = 0;
		hold_left       = 0;
		mdl_link_ready  = 1'b0;
		mdl_power_flag  = 1'b0;
		mdl_status_flag = 1'b0;
		mdl_normal_flag = 1'b0;
		mdl_status_code = '0;
		mdl_normal_code = '0;
		mdl_app         = 1'b0;
		mdl_switch      = 1'b0;
		mdl_duty        = '0;
		mdl_clock       = '0;
		mdl_mask        = '0;
		foreach (mdl_timer[i])
			mdl_timer[i] = '0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		test_link_up();
		test_commands();
		test_type_mask();
		test_random_traffic(16'h0000, 250);
		test_random_traffic(16'hFFFF, 250);
		test_random_traffic(16'($urandom), 250);
		test_random_traffic(16'h0001 << $urandom_range(0, 15), 250);
		test_backpressure();
		test_quiet_stream();

		wait_drained();
		repeat (8) @(posedge clk);
		fail_count += status_q.size();
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
